// ===== rtl/core/adsr_pkg.sv =====
package adsr_pkg;

   localparam logic signed [15:0] TRIG_ONE = 16'sd4096;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_RISE = 2'd1,
      PHASE_FALL = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      CTRL_IDLE,
      CTRL_EVAL,
      CTRL_MUL,
      CTRL_LOAD,
      CTRL_DIV,
      CTRL_WRITE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic mul;
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

endpackage

// ===== rtl/core/adsr_envelope_generator.sv =====
// Linear ADSR envelope generator: one request transfer per audio sample tick
// (gate level plus attack, decay, sustain, release) yields one response
// transfer with the envelope level (unsigned Q1.15 at the default width) and
// phase (0 idle, 1 attack/decay/sustain, 2 release). A tick that needs a ramp
// value is captured, evaluated, multiplied into a register, loaded into a
// restoring divider that retires one quotient bit per cycle, and written;
// edges, idle, the end of release and sustain with a zero decay time skip
// the divider. A finished result waits in the output register while the
// next request is taken; the next result is held back until that response
// is taken. tick_step resets to 1; the user must write it through csr_wr_en/
// csr_wr_data only while no tick is in flight; the block does not check this.
module adsr_envelope_generator #(
   parameter int TIME_WIDTH          = 24,
   parameter int LEVEL_FRACTION_BITS = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [15:0]                    csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_trigger_level,
   input  logic [TIME_WIDTH-1:0]          req_attack_time,
   input  logic [TIME_WIDTH-1:0]          req_decay_time,
   input  logic [LEVEL_FRACTION_BITS:0]   req_sustain_level,
   input  logic [TIME_WIDTH-1:0]          req_release_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [LEVEL_FRACTION_BITS:0]   rsp_envelope_level,
   output logic [1:0]                     rsp_envelope_phase
);

   adsr_pkg::cmd_type    cmd;
   adsr_pkg::status_type status;

   adsr_ctrl #(
      .LEVEL_WIDTH(LEVEL_FRACTION_BITS + 1)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .status   (status)
   );

   adsr_dpath #(
      .TIME_WIDTH         (TIME_WIDTH),
      .LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_trigger_level (req_trigger_level),
      .req_attack_time   (req_attack_time),
      .req_decay_time    (req_decay_time),
      .req_sustain_level (req_sustain_level),
      .req_release_time  (req_release_time),
      .rsp_envelope_level(rsp_envelope_level),
      .rsp_envelope_phase(rsp_envelope_phase)
   );

endmodule

// ===== rtl/core/adsr_ctrl.sv =====
module adsr_ctrl #(
   parameter int LEVEL_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output adsr_pkg::cmd_type    cmd,
   input  adsr_pkg::status_type status
);

   localparam int CW = $clog2(LEVEL_WIDTH);

   adsr_pkg::ctrl_state_type state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adsr_pkg::CTRL_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         adsr_pkg::CTRL_IDLE: begin
            if (req_valid) begin
               state_in = adsr_pkg::CTRL_EVAL;
            end
         end
         adsr_pkg::CTRL_EVAL:  state_in = adsr_pkg::CTRL_MUL;
         adsr_pkg::CTRL_MUL: begin
            state_in = status.need_div ? adsr_pkg::CTRL_LOAD : adsr_pkg::CTRL_WRITE;
         end
         adsr_pkg::CTRL_LOAD:  state_in = adsr_pkg::CTRL_DIV;
         adsr_pkg::CTRL_DIV: begin
            if (count_ff == '0) begin
               state_in = adsr_pkg::CTRL_WRITE;
            end
         end
         adsr_pkg::CTRL_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = adsr_pkg::CTRL_IDLE;
            end
         end
         default: state_in = adsr_pkg::CTRL_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      count_in     = count_ff;
      unique case (state_ff)
         adsr_pkg::CTRL_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         adsr_pkg::CTRL_EVAL: cmd.eval = 1'b1;
         adsr_pkg::CTRL_MUL:  cmd.mul = 1'b1;
         adsr_pkg::CTRL_LOAD: begin
            cmd.load = 1'b1;
            count_in = CW'(LEVEL_WIDTH - 1);
         end
         adsr_pkg::CTRL_DIV: begin
            cmd.step = 1'b1;
            count_in = count_ff - 1'b1;
         end
         adsr_pkg::CTRL_WRITE: cmd.commit = !rsp_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == adsr_pkg::CTRL_EVAL))
      else $error("accepted transfer did not start evaluation");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == adsr_pkg::CTRL_WRITE && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == adsr_pkg::CTRL_WRITE && rsp_valid_ff))
      else $error("result written over a stalled transfer");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid_ff && state_ff == adsr_pkg::CTRL_IDLE))
      else $error("commit did not present a result");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

endmodule

// ===== rtl/core/adsr_dpath.sv =====
module adsr_dpath #(
   parameter int TIME_WIDTH          = 24,
   parameter int LEVEL_FRACTION_BITS = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  adsr_pkg::cmd_type              cmd,
   output adsr_pkg::status_type           status,
   input  logic                           csr_wr_en,
   input  logic [15:0]                    csr_wr_data,
   input  logic signed [15:0]             req_trigger_level,
   input  logic [TIME_WIDTH-1:0]          req_attack_time,
   input  logic [TIME_WIDTH-1:0]          req_decay_time,
   input  logic [LEVEL_FRACTION_BITS:0]   req_sustain_level,
   input  logic [TIME_WIDTH-1:0]          req_release_time,
   output logic [LEVEL_FRACTION_BITS:0]   rsp_envelope_level,
   output logic [1:0]                     rsp_envelope_phase
);

   localparam int TW = TIME_WIDTH;
   localparam int L  = LEVEL_FRACTION_BITS + 1;
   localparam int EW = TW + 1;
   localparam int IW = ((EW > 16) ? EW : 16) + 1;
   localparam int N  = L + TW;
   localparam logic [L-1:0] ONE = {1'b1, {LEVEL_FRACTION_BITS{1'b0}}};

   logic [15:0]         tick_step_ff;
   logic signed [15:0]  prev_ff;
   logic [EW-1:0]       elapsed_ff;
   adsr_pkg::phase_type phase_ff;
   logic [L-1:0]        held_ff;

   logic signed [15:0]  trig_ff;
   logic [TW-1:0]       atk_ff, dec_ff, rel_ff;
   logic [L-1:0]        sus_ff, sus_in;
   logic [EW-1:0]       sum_ad_ff;
   logic [IW-1:0]       inc_ff;

   logic [L-1:0]        mul_a_ff, mul_a_in;
   logic [TW-1:0]       mul_b_ff, mul_b_in;
   logic [TW-1:0]       divisor_ff, divisor_in;
   logic                invert_ff, invert_in;
   logic                need_div_ff, need_div_in;
   logic [L-1:0]        direct_level_ff, direct_level_in;
   logic [EW-1:0]       new_elapsed_ff, new_elapsed_in;
   adsr_pkg::phase_type new_phase_ff, new_phase_in;

   logic [N-1:0]        product_ff, product_in;
   logic [TW-1:0]       rem_ff, rem_in;
   logic [L-1:0]        quo_ff, quo_in;

   logic                rise_edge, fall_edge, inc_lt_atk, inc_lt_rel, inc_lt_sum, dec_nz;
   logic [IW-1:0]       atk_ext, rel_ext, sum_ext, diff_ia, diff_ri;
   logic [EW-1:0]       e_rise;
   logic [TW-1:0]       dec_span;
   logic [L-1:0]        peak, result_level;
   logic [TW:0]         trial, trial_diff;
   logic                fits;

   assign sus_in = (req_sustain_level > ONE) ? ONE : req_sustain_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff <= 16'd1;
         prev_ff      <= '0;
         elapsed_ff   <= '0;
         phase_ff     <= adsr_pkg::PHASE_IDLE;
         held_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            tick_step_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            prev_ff    <= trig_ff;
            elapsed_ff <= new_elapsed_ff;
            phase_ff   <= new_phase_ff;
            held_ff    <= result_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         trig_ff   <= req_trigger_level;
         atk_ff    <= req_attack_time;
         dec_ff    <= req_decay_time;
         rel_ff    <= req_release_time;
         sus_ff    <= sus_in;
         sum_ad_ff <= {1'b0, req_attack_time} + {1'b0, req_decay_time};
         inc_ff    <= {{(IW-EW){1'b0}}, elapsed_ff} + {{(IW-16){1'b0}}, tick_step_ff};
      end
      if (cmd.eval) begin
         mul_a_ff        <= mul_a_in;
         mul_b_ff        <= mul_b_in;
         divisor_ff      <= divisor_in;
         invert_ff       <= invert_in;
         need_div_ff     <= need_div_in;
         direct_level_ff <= direct_level_in;
         new_elapsed_ff  <= new_elapsed_in;
         new_phase_ff    <= new_phase_in;
      end
      if (cmd.mul) begin
         product_ff <= product_in;
      end
      if (cmd.load) begin
         rem_ff <= product_ff[N-1:L];
         quo_ff <= product_ff[L-1:0];
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rise_edge  = (trig_ff >= adsr_pkg::TRIG_ONE) && (prev_ff <= 16'sd0);
   assign fall_edge  = (trig_ff <= 16'sd0) && (prev_ff >= adsr_pkg::TRIG_ONE);
   assign atk_ext    = {{(IW-TW){1'b0}}, atk_ff};
   assign rel_ext    = {{(IW-TW){1'b0}}, rel_ff};
   assign sum_ext    = {{(IW-EW){1'b0}}, sum_ad_ff};
   assign inc_lt_atk = inc_ff < atk_ext;
   assign inc_lt_rel = inc_ff < rel_ext;
   assign inc_lt_sum = inc_ff < sum_ext;
   assign diff_ia    = inc_ff - atk_ext;
   assign diff_ri    = rel_ext - inc_ff;
   assign e_rise     = inc_lt_sum ? inc_ff[EW-1:0] : sum_ad_ff;
   assign dec_span   = inc_lt_sum ? diff_ia[TW-1:0] : dec_ff;
   assign dec_nz     = dec_ff != '0;
   assign peak       = dec_nz ? ONE : sus_ff;

   always_comb begin
      mul_a_in        = peak;
      mul_b_in        = inc_ff[TW-1:0];
      divisor_in      = atk_ff;
      invert_in       = 1'b0;
      need_div_in     = 1'b0;
      direct_level_in = held_ff;
      new_elapsed_in  = elapsed_ff;
      new_phase_in    = phase_ff;
      if (rise_edge) begin
         direct_level_in = '0;
         new_elapsed_in  = '0;
         new_phase_in    = adsr_pkg::PHASE_RISE;
      end else if (fall_edge) begin
         direct_level_in = sus_ff;
         new_elapsed_in  = '0;
         new_phase_in    = adsr_pkg::PHASE_FALL;
      end else begin
         case (phase_ff)
            adsr_pkg::PHASE_RISE: begin
               new_elapsed_in = e_rise;
               if (inc_lt_atk) begin
                  need_div_in = 1'b1;
               end else if (dec_nz) begin
                  need_div_in = 1'b1;
                  mul_a_in    = ONE - sus_ff;
                  mul_b_in    = dec_span;
                  divisor_in  = dec_ff;
                  invert_in   = 1'b1;
               end else begin
                  direct_level_in = sus_ff;
               end
            end
            adsr_pkg::PHASE_FALL: begin
               if (inc_lt_rel) begin
                  new_elapsed_in = inc_ff[EW-1:0];
                  need_div_in    = 1'b1;
                  mul_a_in       = sus_ff;
                  mul_b_in       = diff_ri[TW-1:0];
                  divisor_in     = rel_ff;
               end else begin
                  new_elapsed_in  = {1'b0, rel_ff};
                  new_phase_in    = adsr_pkg::PHASE_IDLE;
                  direct_level_in = '0;
               end
            end
            default: begin
               new_phase_in = phase_ff;
            end
         endcase
      end
   end

   assign product_in = mul_a_ff * mul_b_ff;

   assign trial      = {rem_ff, quo_ff[L-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign fits       = trial >= {1'b0, divisor_ff};
   assign rem_in     = fits ? trial_diff[TW-1:0] : trial[TW-1:0];
   assign quo_in     = {quo_ff[L-2:0], fits};

   assign result_level = need_div_ff ? (invert_ff ? ONE - quo_ff : quo_ff) : direct_level_ff;

   assign status.need_div    = need_div_ff;
   assign rsp_envelope_level = held_ff;
   assign rsp_envelope_phase = phase_ff;

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= ONE)
      else $error("envelope level above one");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == adsr_pkg::PHASE_IDLE) || (phase_ff == adsr_pkg::PHASE_RISE)
      || (phase_ff == adsr_pkg::PHASE_FALL))
      else $error("unused envelope phase code");

   a_idle_level_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == adsr_pkg::PHASE_IDLE) |-> (held_ff == '0))
      else $error("idle phase with a nonzero level");

endmodule
